[hw/rtl/mvbr_pkg.sv]
// ----------------------------------------------------------------------------
// mvbr_pkg
// shared types, field widths and request codes for the dense layer block
// ----------------------------------------------------------------------------
package mvbr_pkg;

    // fixed field widths of the word ports
    localparam int TYPE_W = 2;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 5;
    localparam int DATA_W = 32;
    localparam int OUT_W  = 31;

    // default array shape
    localparam int DEF_ROWS = 32;
    localparam int DEF_COLS = 32;

    // request codes
    typedef enum logic [TYPE_W-1:0] {
        REQ_VEC    = 2'd0,
        REQ_BIAS   = 2'd1,
        REQ_WEIGHT = 2'd2,
        REQ_START  = 2'd3
    } t_req;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // load word accepted this cycle
        logic clear;  // compute run accepted, rewind sequence counters
        logic step;   // issue one multiply-accumulate read
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic issue_last;  // current position is the last row and column
        logic run_done;    // final row result on the output this cycle
    } t_sts;

endpackage

[hw/rtl/matvec_bias_relu.sv]
// ----------------------------------------------------------------------------
// matvec_bias_relu
// fully connected layer: bias plus weight matrix times vector, then relu
// ----------------------------------------------------------------------------
// usage
//   one input channel: a word is taken at a clock edge with start high and
//   busy low; i_req_type picks load vector element, load bias, load weight
//   or start compute
//   load words never raise busy, so while busy is low loads stream back to
//   back at one word per cycle; out-of-range row or col is ignored
//   a start word raises busy for the whole run: one multiply-accumulate
//   per cycle through a single multiplier fed by one weight ram read port
//   results: one word per row, in row order, each shown for one cycle with
//   o_strobe high; each row comes out once its last column has passed the
//   read, product and accumulator stages; o_out_last marks the final row
//   and busy drops the cycle after it
//   the receiver cannot stall: every strobed word must be taken as shown
//   reset clears the controller and pipeline valids only; the stores hold
//   garbage until written and must be loaded before a compute run reads them
//   sums wrap modulo 2^32 before the relu clamp
// ----------------------------------------------------------------------------
module matvec_bias_relu #(
    parameter int ROWS = mvbr_pkg::DEF_ROWS,
    parameter int COLS = mvbr_pkg::DEF_COLS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command channel
    input  logic                               start,
    output logic                               busy,
    input  logic [mvbr_pkg::TYPE_W-1:0]        i_req_type,
    input  logic [mvbr_pkg::ROW_W-1:0]         i_row,
    input  logic [mvbr_pkg::COL_W-1:0]         i_col,
    input  logic signed [mvbr_pkg::DATA_W-1:0] i_value,
    // result channel
    output logic                               o_strobe,
    output logic [mvbr_pkg::ROW_W-1:0]         o_out_row,
    output logic [mvbr_pkg::OUT_W-1:0]         o_out_value,
    output logic                               o_out_last
);

    mvbr_pkg::t_cmd cmd;
    mvbr_pkg::t_sts sts;

    // sequencing and handshake
    mvbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // stores and multiply-accumulate pipeline
    mvbr_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_type  (i_req_type),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_out_row   (o_out_row),
        .o_out_value (o_out_value),
        .o_out_last  (o_out_last)
    );

endmodule

[hw/rtl/mvbr_ram.sv]
// ----------------------------------------------------------------------------
// mvbr_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module mvbr_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/mvbr_ctrl.sv]
// ----------------------------------------------------------------------------
// mvbr_ctrl
// controller: accepts words, sequences a compute run and drives busy
// ----------------------------------------------------------------------------
module mvbr_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [mvbr_pkg::TYPE_W-1:0]      i_req_type,
    input  mvbr_pkg::t_sts                   i_sts,
    output mvbr_pkg::t_cmd                   o_cmd,
    output logic                             busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   accept;
    logic   is_run;

    assign accept = start & ~r_busy;
    assign is_run = (i_req_type == mvbr_pkg::REQ_START);

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = accept & ~is_run;
        o_cmd.clear = accept & is_run;
        o_cmd.step  = (r_state == ST_RUN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept && is_run) begin
                        r_state <= ST_RUN;
                        r_busy  <= 1'b1;
                    end
                end
                ST_RUN: begin
                    if (i_sts.issue_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (i_sts.run_done) begin
                        r_state <= ST_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = r_busy;

endmodule

[hw/rtl/mvbr_datapath.sv]
// ----------------------------------------------------------------------------
// mvbr_datapath
// stores, sequence counters and the multiply-accumulate pipeline
// ----------------------------------------------------------------------------
module mvbr_datapath #(
    parameter int ROWS = mvbr_pkg::DEF_ROWS,
    parameter int COLS = mvbr_pkg::DEF_COLS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mvbr_pkg::t_cmd                    i_cmd,
    output mvbr_pkg::t_sts                    o_sts,
    input  logic [mvbr_pkg::TYPE_W-1:0]       i_req_type,
    input  logic [mvbr_pkg::ROW_W-1:0]        i_row,
    input  logic [mvbr_pkg::COL_W-1:0]        i_col,
    input  logic signed [mvbr_pkg::DATA_W-1:0] i_value,
    output logic                              o_strobe,
    output logic [mvbr_pkg::ROW_W-1:0]        o_out_row,
    output logic [mvbr_pkg::OUT_W-1:0]        o_out_value,
    output logic                              o_out_last
);

    localparam int DW    = mvbr_pkg::DATA_W;
    localparam int OROW  = mvbr_pkg::ROW_W;
    localparam int OW    = mvbr_pkg::OUT_W;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WAW   = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1;

    // load decode
    logic          row_ok;
    logic          col_ok;
    logic          vec_we;
    logic          bias_we;
    logic          wt_we;
    logic [WAW-1:0] wt_waddr;

    assign row_ok   = (32'(i_row) < ROWS);
    assign col_ok   = (32'(i_col) < COLS);
    assign vec_we   = i_cmd.load && (i_req_type == mvbr_pkg::REQ_VEC) && col_ok;
    assign bias_we  = i_cmd.load && (i_req_type == mvbr_pkg::REQ_BIAS) && row_ok;
    assign wt_we    = i_cmd.load && (i_req_type == mvbr_pkg::REQ_WEIGHT) && row_ok && col_ok;
    assign wt_waddr = WAW'(32'(i_row) * COLS + 32'(i_col));

    // sequence counters
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [WAW-1:0] r_waddr;
    logic           col_last;
    logic           row_last;

    assign col_last = (r_col == CW'(COLS - 1));
    assign row_last = (r_row == RW'(ROWS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_col   <= '0;
            r_row   <= '0;
            r_waddr <= '0;
        end else if (i_cmd.step) begin
            r_waddr <= r_waddr + WAW'(1);
            if (col_last) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    assign o_sts.issue_last = i_cmd.step & col_last & row_last;

    // stores
    logic [DW-1:0] vec_rdata;
    logic [DW-1:0] bias_rdata;
    logic [DW-1:0] wt_rdata;

    mvbr_ram #(.W(DW), .DEPTH(COLS)) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (CW'(i_col)),
        .i_wdata (i_value),
        .i_raddr (r_col),
        .o_rdata (vec_rdata)
    );

    mvbr_ram #(.W(DW), .DEPTH(ROWS)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (bias_we),
        .i_waddr (RW'(i_row)),
        .i_wdata (i_value),
        .i_raddr (r_row),
        .o_rdata (bias_rdata)
    );

    mvbr_ram #(.W(DW), .DEPTH(ROWS * COLS)) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (i_value),
        .i_raddr (r_waddr),
        .o_rdata (wt_rdata)
    );

    // stage 1: read data arrives
    logic          r_v1, r_first1, r_last1, r_lrow1;
    logic [RW-1:0] r_row1;
    // stage 2: product
    logic          r_v2, r_first2, r_last2, r_lrow2;
    logic [RW-1:0] r_row2;
    logic [DW-1:0] r_prod;
    logic [DW-1:0] r_bias2;
    logic [2*DW-1:0] full_prod;
    // stage 3: accumulator
    logic          r_done3, r_lrow3;
    logic [RW-1:0] r_row3;
    logic [DW-1:0] r_acc;

    assign full_prod = vec_rdata * wt_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done3 <= 1'b0;
        end else begin
            r_v1    <= i_cmd.step;
            r_v2    <= r_v1;
            r_done3 <= r_v2 & r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= (r_col == '0);
        r_last1  <= col_last;
        r_lrow1  <= row_last;
        r_row1   <= r_row;

        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_lrow2  <= r_lrow1;
        r_row2   <= r_row1;
        r_prod   <= full_prod[DW-1:0];
        r_bias2  <= bias_rdata;

        r_lrow3  <= r_lrow2;
        r_row3   <= r_row2;
        if (r_v2) begin
            // wraps modulo 2^32
            if (r_first2) begin
                r_acc <= r_bias2 + r_prod;
            end else begin
                r_acc <= r_acc + r_prod;
            end
        end
    end

    // relu clamp
    assign o_strobe    = r_done3;
    assign o_out_row   = OROW'(r_row3);
    assign o_out_value = r_acc[DW-1] ? '0 : r_acc[OW-1:0];
    assign o_out_last  = r_done3 & r_lrow3;
    assign o_sts.run_done = r_done3 & r_lrow3;

endmodule

[hw/rtl/mvbr_checker.sv]
// ----------------------------------------------------------------------------
// mvbr_checker
// port-level checks on busy and result sequencing
// ----------------------------------------------------------------------------
module mvbr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [mvbr_pkg::TYPE_W-1:0]   i_req_type,
    input logic                          o_strobe,
    input logic                          o_out_last
);

    // results only appear inside a compute run
    a_strobe_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result word outside a compute run");

    // the last row ends the run
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out_last) |=> !busy)
        else $error("busy held after last row");

    // a start word opens a run
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == mvbr_pkg::REQ_START) |=> busy)
        else $error("start word did not raise busy");

    // load words never occupy the block
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type != mvbr_pkg::REQ_START) |=> !busy)
        else $error("load word raised busy");

endmodule

bind matvec_bias_relu mvbr_checker u_mvbr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_req_type (i_req_type),
    .o_strobe   (o_strobe),
    .o_out_last (o_out_last)
);

[dv/matvec_bias_relu_test.sv]
// ----------------------------------------------------------------------------
// matvec_bias_relu_test
// self-checking bench for the dense layer block: loads the vector, bias and
// weight stores, fires compute runs and checks every row word against an
// in-bench model of bias plus weight times vector, wrapped to 32 bits, then
// clamped by relu
// ----------------------------------------------------------------------------
module matvec_bias_relu_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mvbr_pkg::*;

    // array shape under test, the design default
    localparam int N_ROWS       = 32;
    localparam int N_COLS       = 32;
    // random words, loads and starts, to send after the directed part
    localparam int RANDOM_WORDS = 450;

    // one expected row word
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [OUT_W-1:0] value;
        logic             last;
    } t_row_result;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    logic [TYPE_W-1:0]         i_req_type  = REQ_VEC;
    logic [ROW_W-1:0]          i_row       = '0;
    logic [COL_W-1:0]          i_col       = '0;
    logic signed [DATA_W-1:0]  i_value     = '0;
    logic                      o_strobe;
    logic [ROW_W-1:0]          o_out_row;
    logic [OUT_W-1:0]          o_out_value;
    logic                      o_out_last;

    // shadow copies of the three stores, updated as load words are taken
    logic [DATA_W-1:0] vector_mem [N_COLS];
    logic [DATA_W-1:0] bias_mem   [N_ROWS];
    logic [DATA_W-1:0] weight_mem [N_ROWS][N_COLS];

    // row words still owed by the block, oldest first
    t_row_result expected_rows [$];
    int          mismatch_count = 0;
    // words left in the current sender burst
    int          burst_left     = 0;

    matvec_bias_relu #(
        .ROWS(N_ROWS),
        .COLS(N_COLS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req_type (i_req_type),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_value    (i_value),
        .o_strobe   (o_strobe),
        .o_out_row  (o_out_row),
        .o_out_value(o_out_value),
        .o_out_last (o_out_last)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // model of one compute run: every row in order, 32-bit wrap, then relu
    function automatic void predict_layer();
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] prod;
        t_row_result       res;
        for (int r = 0; r < N_ROWS; r++) begin
            acc = bias_mem[r];
            for (int c = 0; c < N_COLS; c++) begin
                prod = weight_mem[r][c] * vector_mem[c];
                acc  = acc + prod;
            end
            res.row   = r[ROW_W-1:0];
            // a negative wrapped sum clamps to zero
            res.value = acc[DATA_W-1] ? '0 : acc[OUT_W-1:0];
            res.last  = (r == N_ROWS - 1);
            expected_rows.push_back(res);
        end
    endfunction

    // drive one word, hold it until the block takes it, then update the model
    // start is left high so that a following word goes out with no gap
    // row and col selects keep only the bits of their ports
    task automatic send_word(input t_req kind, input int row_sel, input int col_sel,
                             input logic [DATA_W-1:0] value);
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        row        = row_sel[ROW_W-1:0];
        col        = col_sel[COL_W-1:0];
        start      <= 1'b1;
        i_req_type <= kind;
        i_row      <= row;
        i_col      <= col;
        i_value    <= value;
        // taken at the first edge that sees busy low
        do @(posedge i_clk); while (busy);
        case (kind)
            REQ_VEC: begin
                if (col < N_COLS) vector_mem[col] = value;
            end
            REQ_BIAS: begin
                if (row < N_ROWS) bias_mem[row] = value;
            end
            REQ_WEIGHT: begin
                if (row < N_ROWS && col < N_COLS) weight_mem[row][col] = value;
            end
            REQ_START: begin
                predict_layer();
            end
        endcase
    endtask

    // sender idle for a number of cycles
    task automatic idle(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // burst pacing: after each word, either carry on or take a random gap
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle($urandom_range(1, 6));
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // hold off until every owed row word has come out
    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_rows.size() != 0) @(posedge i_clk);
    endtask

    // data word mixing extremes, small signed values and full random
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return $urandom_range(0, 511) - 256;
            default: return $urandom;
        endcase
    endfunction

    // every store entry written before any compute run reads it; the vector
    // starts at zero so the first run shows the bias through the relu alone
    task automatic test_store_fill();
        for (int c = 0; c < N_COLS; c++)
            send_word(REQ_VEC, $urandom, c, '0);
        for (int r = 0; r < N_ROWS; r++)
            send_word(REQ_BIAS, r, $urandom, rand_word());
        for (int r = 0; r < N_ROWS; r++)
            for (int c = 0; c < N_COLS; c++)
                send_word(REQ_WEIGHT, r, c, rand_word());
        idle(2);
    endtask

    // zero vector: each row is relu(bias), with bias at its extremes
    task automatic test_bias_relu();
        send_word(REQ_BIAS, 0, 0, 32'h7FFF_FFFF);
        send_word(REQ_BIAS, 1, 0, 32'h8000_0000);
        send_word(REQ_BIAS, 2, 0, 32'h0000_0000);
        send_word(REQ_BIAS, 3, 0, 32'hFFFF_FFFF);
        send_word(REQ_BIAS, 31, 31, 32'h0000_0001);
        send_word(REQ_START, 0, 0, 32'h0);
        wait_for_results();
    endtask

    // accumulator wrap: max bias plus one goes negative and clamps, minus one
    // plus two wraps back to positive, and min times minus one in the last
    // row and column
    task automatic test_accumulator_wrap();
        send_word(REQ_VEC, 0, 0, 32'h0000_0001);
        send_word(REQ_WEIGHT, 0, 0, 32'h0000_0001);
        send_word(REQ_WEIGHT, 3, 0, 32'h0000_0002);
        send_word(REQ_WEIGHT, 1, 0, 32'h8000_0000);
        send_word(REQ_VEC, 31, 31, 32'h8000_0000);
        send_word(REQ_WEIGHT, 31, 31, 32'hFFFF_FFFF);
        send_word(REQ_START, 31, 31, 32'hFFFF_FFFF);
        idle(1);
    endtask

    // a start right behind a start, then a load held off by busy, then a run
    // that sees the new vector element
    task automatic test_back_to_back_runs();
        send_word(REQ_START, 0, 0, 32'h0);
        send_word(REQ_START, 5, 5, 32'h5555_5555);
        send_word(REQ_VEC, 0, 5, 32'h0000_0003);
        send_word(REQ_START, 31, 0, 32'hAAAA_AAAA);
        wait_for_results();
    endtask

    // random layers: runs of random loads, each closed by a start; a few
    // runs are short so that starts land close together
    task automatic test_random_layers();
        int   loads_in_layer;
        int   sent;
        bit   drained;
        t_req kind;
        int   pick;
        sent    = 0;
        drained = 1'b0;
        while (sent < RANDOM_WORDS) begin
            loads_in_layer = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                         : $urandom_range(8, 40);
            repeat (loads_in_layer) begin
                pick = $urandom_range(0, 19);
                kind = (pick < 5) ? REQ_VEC : (pick < 8) ? REQ_BIAS : REQ_WEIGHT;
                send_word(kind, $urandom, $urandom, rand_word());
                pace();
                sent++;
            end
            // once midway the sender waits for the block to drain
            if (!drained && sent >= RANDOM_WORDS / 2) begin
                wait_for_results();
                drained = 1'b1;
            end
            send_word(REQ_START, $urandom, $urandom, $urandom);
            pace();
            sent++;
        end
    endtask

    // sequence of tests, then drain and verdict
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_store_fill();
        test_bias_relu();
        test_accumulator_wrap();
        test_back_to_back_runs();
        test_random_layers();

        wait_for_results();
        // wait on to catch any stray word
        repeat (N_COLS + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // each strobed word is compared against the oldest expected row word
    always @(posedge i_clk) begin : row_check
        t_row_result want;
        if (i_rst_n && $isunknown(o_strobe)) begin
            $display("%0t: strobe is unknown", $time);
            mismatch_count++;
        end else if (i_rst_n && o_strobe) begin
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected word: row %0d value %0d last %0b",
                         $time, o_out_row, o_out_value, o_out_last);
                mismatch_count++;
            end else begin
                want = expected_rows.pop_front();
                if (o_out_row !== want.row) begin
                    $display("%0t: row index: expected %0d, actual %0d",
                             $time, want.row, o_out_row);
                    mismatch_count++;
                end
                if (o_out_value !== want.value) begin
                    $display("%0t: row %0d value: expected %0d, actual %0d",
                             $time, want.row, want.value, o_out_value);
                    mismatch_count++;
                end
                if (o_out_last !== want.last) begin
                    $display("%0t: row %0d last flag: expected %0b, actual %0b",
                             $time, want.row, want.last, o_out_last);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit, far above the slowest correct run
    initial begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
hw/rtl/mvbr_pkg.sv
hw/rtl/mvbr_ram.sv
hw/rtl/mvbr_ctrl.sv
hw/rtl/mvbr_datapath.sv
hw/rtl/matvec_bias_relu.sv
hw/rtl/mvbr_checker.sv
dv/matvec_bias_relu_test.sv
